>>> src/bed_pkg.sv
// Shared constants and types for the bounded edit distance block.
package bed_pkg;

  // String buffer depth and derived widths
  localparam int MAX_LEN = 96;
  localparam int LEN_W   = $clog2(MAX_LEN + 1);
  localparam int IDX_W   = $clog2(MAX_LEN);

  // Fixed field widths
  localparam int MODE_W = 2;
  localparam int SYM_W  = 8;
  localparam int CEIL_W = 7;
  localparam int DIST_W = 7;

  // Width used when comparing table values against the ceiling
  localparam int CMP_W = (LEN_W > CEIL_W) ? LEN_W : CEIL_W;

  // Input item modes
  typedef enum logic [MODE_W-1:0] {
    MODE_FIRST   = 2'd0,
    MODE_SECOND  = 2'd1,
    MODE_COMPUTE = 2'd2
  } mode_t;

  // Sequencer states
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_ROW  = 5'b00010,
    S_CELL = 5'b00100,
    S_CHK  = 5'b01000,
    S_FIN  = 5'b10000
  } state_t;

endpackage

>>> src/bed_if.sv
// Channel interfaces: input items and result items.
interface bed_in_if;
  logic                        valid;
  logic                        ready;
  logic [bed_pkg::MODE_W-1:0]  mode;
  logic [bed_pkg::SYM_W-1:0]   symbol;
  logic [bed_pkg::CEIL_W-1:0]  ceiling;

  modport source (output valid, output mode, output symbol, output ceiling, input ready);
  modport sink   (input valid, input mode, input symbol, input ceiling, output ready);
endinterface

interface bed_out_if;
  logic                        valid;
  logic                        ready;
  logic [bed_pkg::DIST_W-1:0]  distance;
  logic                        exceeded;
  logic                        overflow;

  modport source (output valid, output distance, output exceeded, output overflow, input ready);
  modport sink   (input valid, input distance, input exceeded, input overflow, output ready);
endinterface

>>> src/bed_cell.sv
// Shared table cell unit: three-way minimum and running row minimum.
module bed_cell (
  input  logic [bed_pkg::LEN_W-1:0] diag,
  input  logic [bed_pkg::LEN_W-1:0] above,
  input  logic [bed_pkg::LEN_W-1:0] left,
  input  logic                      mismatch,
  input  logic [bed_pkg::LEN_W-1:0] best,
  output logic [bed_pkg::LEN_W-1:0] value,
  output logic [bed_pkg::LEN_W-1:0] best_nxt
);
  import bed_pkg::*;

  logic [LEN_W-1:0] sub_cost;
  logic [LEN_W-1:0] del_cost;
  logic [LEN_W-1:0] ins_cost;
  logic [LEN_W-1:0] edge_min;

  // Candidate costs; values stay at or below MAX_LEN + 1 so no carry is lost
  assign sub_cost = diag + LEN_W'(mismatch);
  assign del_cost = above + LEN_W'(1);
  assign ins_cost = left + LEN_W'(1);

  // Pick the cheapest edit
  assign edge_min = (del_cost < ins_cost) ? del_cost : ins_cost;
  assign value    = (sub_cost < edge_min) ? sub_cost : edge_min;

  // Track the smallest entry of the row
  assign best_nxt = (value < best) ? value : best;

endmodule

>>> src/bounded_edit_distance.sv
// Top level: string buffers, row store and cell sequencer for bounded edit distance.
//
//   channel   dir  beat fields
//   in_if     in   mode, symbol, ceiling
//   out_if    out  distance, exceeded, overflow
//
// A load beat (mode 0 or 1) is taken while idle; a mode 3 beat is dropped.
// A compute beat walks the table row by row for string lengths n and m, one
// table cell per cycle through the shared cell unit and the row store port.
// Early exits (length gap, full second string, overflow) go straight to finish.
// Reset is synchronous and clears lengths, flags and the sequencer only.
// in_if.ready is low while a compute runs; a waiting result holds in the output
// register and stalls only the finish of the next compute.
module bounded_edit_distance (
  input logic clk,
  input logic rst_n,
  bed_in_if.sink    in_if,
  bed_out_if.source out_if
);
  import bed_pkg::*;

  // Storage
  logic [SYM_W-1:0] first_mem  [MAX_LEN];
  logic [SYM_W-1:0] second_mem [MAX_LEN];
  logic [LEN_W-1:0] row_mem    [MAX_LEN];

  // Control and work registers
  state_t            state_r, state_nxt;
  logic [LEN_W-1:0]  n_r, m_r;
  logic              ovf_r;
  logic [CEIL_W-1:0] ceil_r;
  logic              ovf_hold_r;
  logic              exc_r;
  logic [LEN_W-1:0]  i_r, j_r;
  logic [LEN_W-1:0]  diag_r, left_r, best_r, last_r;
  logic [SYM_W-1:0]  ca_r, sec_q_r;
  logic [LEN_W-1:0]  row_q_r;

  // Output register
  logic              out_valid_r;
  logic [DIST_W-1:0] dist_r;
  logic              exc_out_r;
  logic              ovf_out_r;

  // Memory port controls
  logic             f_we, s_we, r_we;
  logic             f_re, s_re, r_re;
  logic [IDX_W-1:0] f_raddr, rd_addr, r_waddr;

  // Cell unit connections
  logic [LEN_W-1:0] above;
  logic [LEN_W-1:0] cell_value;
  logic [LEN_W-1:0] cell_best;

  // Compute-start checks
  logic                    accept;
  logic [LEN_W-1:0]        len_gap;
  logic                    early_exit;
  logic                    out_free;
  logic                    fin_exceeded;
  logic [CEIL_W:0]         over_wide;
  logic [DIST_W-1:0]       over_sat;

  assign accept   = in_if.valid && in_if.ready;
  assign in_if.ready = (state_r == S_IDLE);
  assign out_free = !out_valid_r || out_if.ready;

  assign len_gap    = (n_r > m_r) ? (n_r - m_r) : (m_r - n_r);
  assign early_exit = ovf_r || (CMP_W'(len_gap) > CMP_W'(in_if.ceiling)) ||
                      (m_r >= LEN_W'(MAX_LEN));

  // First row uses the implicit row 0 (entry j holds j)
  assign above = (i_r == LEN_W'(1)) ? j_r : row_q_r;

  bed_cell u_cell (
    .diag     (diag_r),
    .above    (above),
    .left     (left_r),
    .mismatch (ca_r != sec_q_r),
    .best     (best_r),
    .value    (cell_value),
    .best_nxt (cell_best)
  );

  // Saturated ceiling+1 and final compare
  assign over_wide    = {1'b0, ceil_r} + (CEIL_W+1)'(1);
  assign over_sat     = over_wide[CEIL_W] ? {DIST_W{1'b1}} : DIST_W'(over_wide[CEIL_W-1:0]);
  assign fin_exceeded = exc_r || (CMP_W'(last_r) > CMP_W'(ceil_r));

  // Memory port decode
  always_comb begin
    f_we    = 1'b0;
    s_we    = 1'b0;
    r_we    = 1'b0;
    f_re    = 1'b0;
    s_re    = 1'b0;
    r_re    = 1'b0;
    f_raddr = IDX_W'(i_r - LEN_W'(1));
    rd_addr = '0;
    r_waddr = IDX_W'(j_r - LEN_W'(1));
    unique case (state_r)
      S_IDLE: begin
        if (accept && in_if.mode == MODE_FIRST && n_r < LEN_W'(MAX_LEN)) f_we = 1'b1;
        if (accept && in_if.mode == MODE_SECOND && m_r < LEN_W'(MAX_LEN)) s_we = 1'b1;
      end
      S_ROW: begin
        f_re = 1'b1;
        s_re = 1'b1;
        r_re = 1'b1;
      end
      S_CELL: begin
        r_we = 1'b1;
        if (j_r != m_r) begin
          s_re    = 1'b1;
          r_re    = 1'b1;
          rd_addr = IDX_W'(j_r);
        end
      end
      S_CHK, S_FIN: ;
      default: ;
    endcase
  end

  // First string store
  always_ff @(posedge clk) begin
    if (f_we) first_mem[IDX_W'(n_r)] <= in_if.symbol;
    if (f_re) ca_r <= first_mem[f_raddr];
  end

  // Second string store
  always_ff @(posedge clk) begin
    if (s_we) second_mem[IDX_W'(m_r)] <= in_if.symbol;
    if (s_re) sec_q_r <= second_mem[rd_addr];
  end

  // Row store: entry j-1 holds table column j of the last finished row
  always_ff @(posedge clk) begin
    if (r_we) row_mem[r_waddr] <= cell_value;
    if (r_re) row_q_r <= row_mem[rd_addr];
  end

  // Sequencer next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (accept && in_if.mode == MODE_COMPUTE) begin
          state_nxt = (early_exit || n_r == '0) ? S_FIN : S_ROW;
        end
      end
      S_ROW:  state_nxt = (m_r == '0) ? S_CHK : S_CELL;
      S_CELL: if (j_r == m_r) state_nxt = S_CHK;
      S_CHK: begin
        if (CMP_W'(best_r) > CMP_W'(ceil_r) || i_r == n_r) state_nxt = S_FIN;
        else state_nxt = S_ROW;
      end
      S_FIN:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      n_r         <= '0;
      m_r         <= '0;
      ovf_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      // Append loads, or empty both strings once the result is loaded
      if (state_r == S_IDLE && accept) begin
        case (in_if.mode)
          MODE_FIRST: begin
            if (n_r < LEN_W'(MAX_LEN)) n_r <= n_r + LEN_W'(1);
            else ovf_r <= 1'b1;
          end
          MODE_SECOND: if (m_r < LEN_W'(MAX_LEN)) m_r <= m_r + LEN_W'(1);
          default: ;
        endcase
      end else if (state_r == S_FIN && out_free) begin
        n_r   <= '0;
        m_r   <= '0;
        ovf_r <= 1'b0;
      end
      // Load a new result, or drop the one just taken
      if (state_r == S_FIN && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_if.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Work registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (accept && in_if.mode == MODE_COMPUTE) begin
          ceil_r     <= in_if.ceiling;
          ovf_hold_r <= ovf_r;
          exc_r      <= early_exit;
          last_r     <= m_r;
          i_r        <= LEN_W'(1);
        end
      end
      S_ROW: begin
        diag_r <= i_r - LEN_W'(1);
        left_r <= i_r;
        best_r <= i_r;
        j_r    <= LEN_W'(1);
      end
      S_CELL: begin
        diag_r <= above;
        left_r <= cell_value;
        best_r <= cell_best;
        if (j_r != m_r) j_r <= j_r + LEN_W'(1);
      end
      S_CHK: begin
        if (CMP_W'(best_r) > CMP_W'(ceil_r)) begin
          exc_r <= 1'b1;
        end else begin
          last_r <= left_r;
          if (i_r != n_r) i_r <= i_r + LEN_W'(1);
        end
      end
      S_FIN: begin
        if (out_free) begin
          exc_out_r <= fin_exceeded;
          ovf_out_r <= ovf_hold_r;
          dist_r    <= fin_exceeded ? over_sat : DIST_W'(last_r);
        end
      end
      default: ;
    endcase
  end

  assign out_if.valid    = out_valid_r;
  assign out_if.distance = dist_r;
  assign out_if.exceeded = exc_out_r;
  assign out_if.overflow = ovf_out_r;

  // An overflowed first string always reports an exceeded result
  a_ovf_exceeded: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && ovf_out_r |-> exc_out_r)
    else $error("overflow reported without exceeded");

  // A result within bounds never passes the ceiling it was asked for
  a_within_ceiling: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) && out_free && !fin_exceeded |-> CMP_W'(last_r) <= CMP_W'(ceil_r))
    else $error("in-bounds result above ceiling");

  // Both strings are empty after a result is loaded
  a_strings_cleared: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_FIN) && out_free |=> n_r == '0 && m_r == '0 && !ovf_r)
    else $error("strings not emptied after compute");

  // The cell column stays inside the second string
  a_column_range: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_CELL |-> j_r != '0 && j_r <= m_r && i_r <= n_r)
    else $error("cell index out of range");

endmodule

>>> verif/testbench.sv
// Self-checking testbench for the bounded edit distance block.
`timescale 1ns / 1ps

module testbench;
  import bed_pkg::*;

  localparam logic [MODE_W-1:0] MODE_NOOP = 2'd3;
  localparam int DIST_MAX     = (1 << DIST_W) - 1;
  localparam int CYCLE_LIMIT  = 2_000_000;
  localparam int ITEM_TARGET  = 2000;
  localparam int DRAIN_CYCLES = 200;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic              exceeded;
    logic              overflow;
  } answer_t;

  typedef enum int {
    JOB_SHORT,
    JOB_NEAR_FULL,
    JOB_FIRST_OVER,
    JOB_SECOND_OVER
  } job_shape_t;

  // String store, distance predictor and queue of pending answers
  class edit_distance_board;
    logic [SYM_W-1:0] first_str[MAX_LEN];
    logic [SYM_W-1:0] second_str[MAX_LEN];
    int               first_len;
    int               second_len;
    bit               first_ovf;
    answer_t          pending_answers[$];
    int               errors;

    task report(string what);
      errors++;
      $display("mismatch: %s", what);
    endtask

    function int waiting();
      return pending_answers.size();
    endfunction

    // Work out the bounded distance over the strings held now
    function answer_t predict(logic [CEIL_W-1:0] ceiling);
      answer_t ans;
      int      ceil_i, cost, gap, best, sub_c, del_c, ins_c, v;
      int      prev_row[MAX_LEN + 1];
      int      cur_row[MAX_LEN + 1];
      bit      pruned;
      ceil_i = int'(ceiling);
      cost   = ceil_i + 1;
      pruned = 1'b1;
      gap    = (first_len > second_len) ? first_len - second_len : second_len - first_len;
      if (!(first_ovf || gap > ceil_i || second_len >= MAX_LEN)) begin
        pruned = 1'b0;
        for (int j = 0; j <= second_len; j++) prev_row[j] = j;
        for (int i = 1; i <= first_len && !pruned; i++) begin
          best       = i;
          cur_row[0] = i;
          for (int j = 1; j <= second_len; j++) begin
            sub_c = prev_row[j-1] + ((first_str[i-1] == second_str[j-1]) ? 0 : 1);
            del_c = prev_row[j] + 1;
            ins_c = cur_row[j-1] + 1;
            v = (sub_c < del_c) ? sub_c : del_c;
            if (ins_c < v) v = ins_c;
            cur_row[j] = v;
            if (v < best) best = v;
          end
          // Stop once the whole row sits above the ceiling
          if (best > ceil_i) pruned = 1'b1;
          else prev_row = cur_row;
        end
        if (!pruned && prev_row[second_len] <= ceil_i) cost = prev_row[second_len];
        else pruned = 1'b1;
      end
      ans.distance = DIST_W'((cost > DIST_MAX) ? DIST_MAX : cost);
      ans.exceeded = pruned;
      ans.overflow = first_ovf;
      return ans;
    endfunction

    // Apply one accepted input beat
    function void note_beat(logic [MODE_W-1:0] mode, logic [SYM_W-1:0] symbol,
                            logic [CEIL_W-1:0] ceiling);
      case (mode)
        MODE_FIRST: begin
          if (first_len < MAX_LEN) first_str[first_len++] = symbol;
          else first_ovf = 1'b1;
        end
        MODE_SECOND: begin
          if (second_len < MAX_LEN) second_str[second_len++] = symbol;
        end
        MODE_COMPUTE: begin
          pending_answers = {pending_answers, predict(ceiling)};
          first_len  = 0;
          second_len = 0;
          first_ovf  = 1'b0;
        end
        default: ;
      endcase
    endfunction

    // Compare one result beat with the oldest pending answer
    task check_answer(logic [DIST_W-1:0] distance, logic exceeded, logic overflow);
      answer_t want;
      if (pending_answers.size() == 0) begin
        report($sformatf("result with nothing pending: distance %0d", distance));
        return;
      end
      want = pending_answers.pop_front();
      if (distance !== want.distance)
        report($sformatf("distance %0d, want %0d", distance, want.distance));
      if (exceeded !== want.exceeded)
        report($sformatf("exceeded %b, want %b", exceeded, want.exceeded));
      if (overflow !== want.overflow)
        report($sformatf("overflow %b, want %b", overflow, want.overflow));
    endtask
  endclass

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  bed_in_if  in_ch();
  bed_out_if out_ch();

  bounded_edit_distance i_dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  edit_distance_board board;
  int items_sent;
  int cycle_count;
  int receiver_hold;
  bit sender_calm;
  bit receiver_calm;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Mostly no gap, often a short one, now and then a long one
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [SYM_W-1:0] pick_symbol(int base, int alpha);
    return SYM_W'((alpha >= 256) ? $urandom_range(0, 255)
                                 : base + $urandom_range(0, alpha - 1));
  endfunction

  // Drive one beat at the falling edge and hold it until accepted
  task automatic send_item(logic [MODE_W-1:0] mode, logic [SYM_W-1:0] symbol,
                           logic [CEIL_W-1:0] ceiling);
    int gap;
    gap = sender_calm ? 0 : idle_len();
    repeat (gap) begin
      @(negedge clk);
      in_ch.valid = 1'b0;
    end
    @(negedge clk);
    in_ch.valid   = 1'b1;
    in_ch.mode    = mode;
    in_ch.symbol  = symbol;
    in_ch.ceiling = ceiling;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    board.note_beat(mode, symbol, ceiling);
    if (mode != MODE_NOOP) items_sent++;
  endtask

  // Load two strings in random interleave, then ask for their distance
  task automatic run_job(job_shape_t shape);
    int               n, m, ia, ib, alpha, base, top;
    bit               mutate;
    logic [SYM_W-1:0] a[$];
    logic [SYM_W-1:0] b[$];
    logic [CEIL_W-1:0] ceiling;
    sender_calm = ($urandom_range(0, 3) == 0);
    mutate      = ($urandom_range(0, 9) < 6);
    alpha       = ($urandom_range(0, 3) == 0) ? 256 : $urandom_range(2, 4);
    base        = (alpha >= 256) ? 0 : $urandom_range(0, 256 - alpha);
    case (shape)
      JOB_FIRST_OVER: begin
        n = $urandom_range(MAX_LEN + 1, MAX_LEN + 4);
        m = $urandom_range(MAX_LEN - 6, MAX_LEN - 1);
      end
      JOB_SECOND_OVER: begin
        n = $urandom_range(MAX_LEN - 6, MAX_LEN);
        m = $urandom_range(MAX_LEN, MAX_LEN + 3);
      end
      JOB_NEAR_FULL: begin
        n = $urandom_range(MAX_LEN - 8, MAX_LEN);
        m = $urandom_range(MAX_LEN - 8, MAX_LEN - 1);
      end
      default: begin
        n = $urandom_range(0, 10);
        m = mutate ? n + $urandom_range(0, 4) - 2 : $urandom_range(0, 10);
        if (m < 0) m = 0;
      end
    endcase
    for (int i = 0; i < n; i++) a = {a, pick_symbol(base, alpha)};
    // A mutated copy keeps distances small enough to land near the ceiling
    for (int j = 0; j < m; j++)
      b = {b, ((mutate && j < n && $urandom_range(0, 4) != 0) ? a[j]
                                                             : pick_symbol(base, alpha))};
    top = (n > m) ? n + 1 : m + 1;
    case ($urandom_range(0, 9))
      0:       ceiling = CEIL_W'($urandom_range(96, 127));
      1:       ceiling = '0;
      2:       ceiling = 7'd95;
      default: ceiling = CEIL_W'($urandom_range(0, (top > 127) ? 127 : top));
    endcase
    if (shape == JOB_FIRST_OVER) ceiling = '1;
    ia = 0;
    ib = 0;
    while (ia < n || ib < m) begin
      if ($urandom_range(0, 29) == 0)
        send_item(MODE_NOOP, SYM_W'($urandom_range(0, 255)), CEIL_W'($urandom_range(0, 127)));
      if (ib >= m || (ia < n && $urandom_range(0, 1) == 0)) begin
        send_item(MODE_FIRST, a[ia], CEIL_W'($urandom_range(0, 127)));
        ia++;
      end else begin
        send_item(MODE_SECOND, b[ib], CEIL_W'($urandom_range(0, 127)));
        ib++;
      end
    end
    // Now and then skip the compute so the next strings pile on top
    if (shape != JOB_SHORT || $urandom_range(0, 19) != 0)
      send_item(MODE_COMPUTE, SYM_W'($urandom_range(0, 255)), ceiling);
  endtask

  // Result side: random stalls with calm stretches
  always @(negedge clk) begin
    if (receiver_hold > 0) begin
      out_ch.ready = 1'b0;
      receiver_hold--;
    end else begin
      out_ch.ready = 1'b1;
      if (!receiver_calm && $urandom_range(0, 2) == 0) receiver_hold = idle_len();
    end
    if ($urandom_range(0, 149) == 0) receiver_calm = !receiver_calm;
  end

  // Check every accepted result beat
  always @(posedge clk) begin
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
      board.check_answer(out_ch.distance, out_ch.exceeded, out_ch.overflow);
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    int         job_count;
    job_shape_t shape;
    board          = new();
    in_ch.valid    = 1'b0;
    in_ch.mode     = MODE_FIRST;
    in_ch.symbol   = '0;
    in_ch.ceiling  = '0;
    out_ch.ready   = 1'b0;
    receiver_hold  = 0;
    receiver_calm  = 1'b0;
    sender_calm    = 1'b0;
    items_sent     = 0;
    cycle_count    = 0;
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Ignored mode with every field bit high, then both strings empty
    send_item(MODE_NOOP, 8'hFF, 7'h7F);
    send_item(MODE_COMPUTE, 8'h00, 7'd0);
    // Extreme symbols, ceiling above its usual range
    send_item(MODE_FIRST, 8'h00, 7'h7F);
    send_item(MODE_SECOND, 8'hFF, 7'd0);
    send_item(MODE_COMPUTE, 8'hA5, 7'd127);
    // Swapped pair: every row passes but the final cell is above the ceiling
    send_item(MODE_FIRST, 8'h61, 7'd0);
    send_item(MODE_FIRST, 8'h62, 7'd0);
    send_item(MODE_SECOND, 8'h62, 7'd0);
    send_item(MODE_SECOND, 8'h61, 7'd0);
    send_item(MODE_COMPUTE, 8'h00, 7'd1);
    // Empty first string
    send_item(MODE_SECOND, 8'h01, 7'd0);
    send_item(MODE_SECOND, 8'h80, 7'd0);
    send_item(MODE_SECOND, 8'h7F, 7'd0);
    send_item(MODE_COMPUTE, 8'h00, 7'd95);
    // Length gap above the ceiling
    send_item(MODE_FIRST, 8'hAA, 7'd0);
    send_item(MODE_COMPUTE, 8'h00, 7'd0);
    // Ignored beat between loads leaves the strings alone
    send_item(MODE_FIRST, 8'h55, 7'd0);
    send_item(MODE_NOOP, 8'h5A, 7'h2A);
    send_item(MODE_SECOND, 8'h55, 7'd0);
    send_item(MODE_COMPUTE, 8'h00, 7'd0);
    // Single row above the ceiling
    send_item(MODE_FIRST, 8'h10, 7'd0);
    send_item(MODE_SECOND, 8'h20, 7'd0);
    send_item(MODE_COMPUTE, 8'h00, 7'd0);

    // Random jobs, with the full-buffer cases placed at fixed points
    job_count = 0;
    while (items_sent < ITEM_TARGET) begin
      case (job_count)
        10:      shape = JOB_FIRST_OVER;
        40:      shape = JOB_SECOND_OVER;
        70:      shape = JOB_NEAR_FULL;
        default: shape = ($urandom_range(0, 99) == 0) ? JOB_NEAR_FULL : JOB_SHORT;
      endcase
      run_job(shape);
      job_count++;
    end
    @(negedge clk);
    in_ch.valid = 1'b0;

    // Drain, then watch for stray results
    while (board.waiting() > 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
